// ===== rtl/bpe_pkg.sv =====
// Package for the byte-pair merge engine: sizes, payload structs and sequencer states.
package bpe_pkg;

	localparam int MAX_RULES  = 4096;
	localparam int MAX_WORD   = 64;
	localparam int TOKEN_BITS = 20;
	localparam int RIDX_BITS  = $clog2(MAX_RULES);
	localparam int RCNT_BITS  = $clog2(MAX_RULES + 1);
	localparam int WIDX_BITS  = $clog2(MAX_WORD);
	localparam int WCNT_BITS  = $clog2(MAX_WORD + 1);

	localparam logic MODE_RULE  = 1'b0;
	localparam logic MODE_TOKEN = 1'b1;

	typedef struct packed {
		logic                  mode;
		logic [TOKEN_BITS-1:0] left_id;
		logic [TOKEN_BITS-1:0] right_id;
		logic [TOKEN_BITS-1:0] joined_id;
		logic [TOKEN_BITS-1:0] token_id;
		logic                  word_end;
	} bpe_in_t;

	typedef struct packed {
		logic [19:0] out_token;
		logic        out_last;
		logic        overflowed;
	} bpe_out_t;

	typedef struct packed {
		logic [TOKEN_BITS-1:0] left;
		logic [TOKEN_BITS-1:0] right;
		logic [TOKEN_BITS-1:0] merged;
	} bpe_rule_t;

	typedef enum logic [13:0] {
		ST_IDLE    = 14'b00000000000001,
		ST_CLEAR   = 14'b00000000000010,
		ST_FIND    = 14'b00000000000100,
		ST_FIND_W  = 14'b00000000001000,
		ST_SHIFT   = 14'b00000000010000,
		ST_SHIFT_W = 14'b00000000100000,
		ST_PAIR    = 14'b00000001000000,
		ST_SCAN    = 14'b00000010000000,
		ST_SCAN_W  = 14'b00000100000000,
		ST_APPLY   = 14'b00001000000000,
		ST_REP     = 14'b00010000000000,
		ST_REP_W   = 14'b00100000000000,
		ST_EMIT    = 14'b01000000000000,
		ST_EMIT_W  = 14'b10000000000000
	} bpe_state_t;

endpackage

// ===== rtl/bpe_merge_engine_unit.sv =====
// Top level of the byte-pair merge engine: rule table, word buffer and merge sequencer.
// The engine is a small sequencer around one shared pair comparator and one rule-table
// memory with one read and one write port. A rule transaction walks the valid part of the
// table looking for the same pair; a duplicate is moved to the end by copying the later
// rules down one place. A token transaction without the word-end mark leaves the engine
// idle. On word end, each merge round walks the rule table in rank order, and for each
// rule compares it against every adjacent pair of the word until the first match; the
// matching rule is then applied in one pass over the word. Results leave through an
// output register. The rule table memory has no reset, so after reset a clearing pass
// over all MAX_RULES entries runs before the first transaction is accepted. The engine
// accepts nothing while a transaction is in work.
module bpe_merge_engine_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  bpe_pkg::bpe_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output bpe_pkg::bpe_out_t out_data
);
	import bpe_pkg::*;

	// Rule table and word buffer, both read with a registered port.
	bpe_rule_t             rule_mem [MAX_RULES];
	bpe_rule_t             rule_rd_q;
	logic [TOKEN_BITS-1:0] word_mem [MAX_WORD];
	logic [TOKEN_BITS-1:0] word_rd_q;

	bpe_state_t            state_q;
	logic [RCNT_BITS-1:0]  rule_count_q;
	logic [RCNT_BITS-1:0]  ridx_q;
	logic [WCNT_BITS-1:0]  wlen_q;
	logic [WCNT_BITS-1:0]  widx_q;
	logic [WCNT_BITS-1:0]  wout_q;
	logic                  overflow_q;
	logic                  pend_q;
	bpe_rule_t             cur_q;
	bpe_rule_t             hold_q;
	logic [TOKEN_BITS-1:0] prev_q;
	logic                  have_prev_q;
	logic                  out_valid_q;
	bpe_out_t              out_q;

	// Memory port controls.
	logic                  rule_we;
	logic [RIDX_BITS-1:0]  rule_wa;
	bpe_rule_t             rule_wd;
	logic [RIDX_BITS-1:0]  rule_ra;
	logic                  word_we;
	logic [WIDX_BITS-1:0]  word_wa;
	logic [TOKEN_BITS-1:0] word_wd;
	logic [WIDX_BITS-1:0]  word_ra;

	logic                  in_acc;
	logic                  pair_hit;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// The one shared comparator: a stored rule against a pair of tokens.
	always_comb begin
		logic [TOKEN_BITS-1:0] a;
		logic [TOKEN_BITS-1:0] b;
		a = cur_q.left;
		b = cur_q.right;
		if (state_q == ST_FIND_W || state_q == ST_SHIFT_W) begin
			a = rule_rd_q.left;
			b = rule_rd_q.right;
		end
		pair_hit = (state_q == ST_SCAN_W || state_q == ST_REP_W) ?
			(have_prev_q && prev_q == a && word_rd_q == b) :
			(hold_q.left == a && hold_q.right == b);
	end

	always_ff @(posedge clk) begin
		if (rule_we) begin
			rule_mem[rule_wa] <= rule_wd;
		end
		rule_rd_q <= rule_mem[rule_ra];
		if (word_we) begin
			word_mem[word_wa] <= word_wd;
		end
		word_rd_q <= word_mem[word_ra];
	end

	// Port addressing follows the sequencer state.
	always_comb begin
		rule_we = 1'b0;
		rule_wa = ridx_q[RIDX_BITS-1:0];
		rule_wd = hold_q;
		rule_ra = ridx_q[RIDX_BITS-1:0];
		word_we = 1'b0;
		word_wa = wlen_q[WIDX_BITS-1:0];
		word_wd = in_data.token_id;
		word_ra = widx_q[WIDX_BITS-1:0];
		unique case (state_q)
			ST_CLEAR: begin
				rule_we = 1'b1;
				rule_wd = '0;
			end
			ST_IDLE: begin
				word_we = in_acc && in_data.mode == MODE_TOKEN &&
					wlen_q < WCNT_BITS'(MAX_WORD);
			end
			ST_SHIFT_W: begin
				// Copy the rule just read one place down, or drop the held rule at the end.
				rule_we = 1'b1;
				rule_wa = RIDX_BITS'(ridx_q - 1'b1);
				rule_wd = (ridx_q == rule_count_q) ? hold_q : rule_rd_q;
			end
			ST_FIND: begin
				rule_we = (ridx_q == rule_count_q) && (rule_count_q < RCNT_BITS'(MAX_RULES));
			end
			ST_REP_W: begin
				word_we = !pair_hit && have_prev_q;
				word_wa = wout_q[WIDX_BITS-1:0];
				word_wd = prev_q;
			end
			ST_APPLY: begin
				word_we = 1'b1;
				word_wa = wout_q[WIDX_BITS-1:0];
				word_wd = have_prev_q ? prev_q : cur_q.merged;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			rule_count_q <= '0;
			ridx_q       <= '0;
			wlen_q       <= '0;
			widx_q       <= '0;
			wout_q       <= '0;
			overflow_q   <= 1'b0;
			pend_q       <= 1'b0;
			have_prev_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			// The output register loads in ST_EMIT_W when free, and empties when taken.
			if (state_q == ST_EMIT_W && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					ridx_q <= ridx_q + 1'b1;
					if (ridx_q == RCNT_BITS'(MAX_RULES - 1)) begin
						ridx_q  <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						if (in_data.mode == MODE_RULE) begin
							hold_q  <= '{in_data.left_id, in_data.right_id, in_data.joined_id};
							ridx_q  <= '0;
							state_q <= ST_FIND;
						end else begin
							if (wlen_q < WCNT_BITS'(MAX_WORD)) begin
								wlen_q <= wlen_q + 1'b1;
							end else begin
								overflow_q <= 1'b1;
							end
							if (in_data.word_end) begin
								ridx_q  <= '0;
								state_q <= ST_PAIR;
							end
						end
					end
				end
				ST_FIND: begin
					if (ridx_q == rule_count_q) begin
						if (rule_count_q < RCNT_BITS'(MAX_RULES)) begin
							rule_count_q <= rule_count_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_FIND_W;
					end
				end
				ST_FIND_W: begin
					ridx_q  <= ridx_q + 1'b1;
					state_q <= pair_hit ? ST_SHIFT : ST_FIND;
				end
				ST_SHIFT: begin
					state_q <= ST_SHIFT_W;
				end
				ST_SHIFT_W: begin
					if (ridx_q == rule_count_q) begin
						state_q <= ST_IDLE;
					end else begin
						ridx_q  <= ridx_q + 1'b1;
						state_q <= ST_SHIFT;
					end
				end
				// Merge round: fetch rules in rank order until one matches a pair; with under two tokens or no rule left, emit.
				ST_PAIR: begin
					if (wlen_q < WCNT_BITS'(2) || ridx_q == rule_count_q) begin
						widx_q  <= '0;
						wout_q  <= '0;
						state_q <= ST_EMIT;
					end else begin
						pend_q  <= 1'b1;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (pend_q) begin
						cur_q  <= rule_rd_q;
						pend_q <= 1'b0;
						widx_q <= '0;
						have_prev_q <= 1'b0;
					end else if (widx_q == wlen_q) begin
						ridx_q  <= ridx_q + 1'b1;
						state_q <= ST_PAIR;
					end else begin
						state_q <= ST_SCAN_W;
					end
				end
				ST_SCAN_W: begin
					if (pair_hit) begin
						widx_q <= '0;
						wout_q <= '0;
						have_prev_q <= 1'b0;
						state_q <= ST_REP;
					end else begin
						prev_q      <= word_rd_q;
						have_prev_q <= 1'b1;
						widx_q      <= widx_q + 1'b1;
						state_q     <= ST_SCAN;
					end
				end
				// Replace pass: prev_q holds a token not yet written back.
				ST_REP: begin
					if (widx_q == wlen_q) begin
						if (have_prev_q) begin
							state_q <= ST_APPLY;
						end else begin
							wlen_q  <= wout_q;
							ridx_q  <= '0;
							state_q <= ST_PAIR;
						end
					end else begin
						state_q <= ST_REP_W;
					end
				end
				ST_REP_W: begin
					widx_q <= widx_q + 1'b1;
					if (pair_hit) begin
						have_prev_q <= 1'b0;
						state_q     <= ST_APPLY;
					end else begin
						if (have_prev_q) begin
							wout_q <= wout_q + 1'b1;
						end
						prev_q      <= word_rd_q;
						have_prev_q <= 1'b1;
						state_q     <= ST_REP;
					end
				end
				ST_APPLY: begin
					wout_q      <= wout_q + 1'b1;
					have_prev_q <= 1'b0;
					state_q     <= ST_REP;
				end
				ST_EMIT: begin
					if (widx_q == wlen_q) begin
						if (!out_valid_q || !out_stall) begin
							wlen_q     <= '0;
							overflow_q <= 1'b0;
							state_q    <= ST_IDLE;
						end
					end else begin
						state_q <= ST_EMIT_W;
					end
				end
				ST_EMIT_W: begin
					if (!out_valid_q || !out_stall) begin
						out_q.out_token  <= 20'(word_rd_q);
						out_q.out_last   <= (widx_q + 1'b1 == wlen_q);
						out_q.overflowed <= overflow_q;
						widx_q  <= widx_q + 1'b1;
						state_q <= ST_EMIT;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/bpe_merge_engine_checker.sv =====
// Port-level checker for the byte-pair merge engine and its bind.
module bpe_merge_engine_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input bpe_pkg::bpe_in_t  in_data,
	input logic              out_valid,
	input logic              out_stall,
	input bpe_pkg::bpe_out_t out_data
);
	import bpe_pkg::*;

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// Rule transactions never produce a result right away.
	a_rule_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.mode == MODE_RULE && !out_valid |=> !out_valid)
		else $error("rule transaction produced a result");

	// A word-ending token always makes the engine busy afterwards.
	a_word_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.mode == MODE_TOKEN && in_data.word_end |=> in_stall)
		else $error("engine idle after word end");

endmodule

bind bpe_merge_engine_unit bpe_merge_engine_checker u_checker (.*);
